FILE: hdl/ricc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ricc_pkg
// Types, codes and fixed-point helpers for the radiation convolution core.
// ----------------------------------------------------------------------------
package ricc_pkg;

	localparam logic [1:0] MODE_KER  = 2'd0;
	localparam logic [1:0] MODE_TPT  = 2'd1;
	localparam logic [1:0] MODE_STEP = 2'd2;

	localparam int DOF_MAX = 6;
	localparam int CW      = 3;
	localparam logic [31:0] DENS_RESET = 32'd65536000;

	typedef struct packed {
		logic vld;
		logic col_first;
		logic col_last;
		logic hist_first;
		logic hist_last;
	} tag_t;

	function automatic logic signed [63:0] rnd_shift16(input logic [63:0] mag,
		input logic neg);
		logic [63:0] r;
		r = (mag + 64'd32768) >> 16;
		return neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic [31:0] neg_sat32(input logic signed [63:0] acc);
		if (acc >= 64'sd2147483648)
			return 32'h80000000;
		if (acc <= -64'sd2147483648)
			return 32'h7fffffff;
		return 32'(-acc);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ricc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ricc_lane
// One force row: kernel store, scaled column products, trapezoid areas and
// the saturating accumulator.
// ----------------------------------------------------------------------------
module ricc_lane import ricc_pkg::*; #(
	parameter int HISTORY_STEPS = 256,
	parameter int DOF_COUNT     = 6,
	parameter int KAW           = $clog2(DOF_COUNT * HISTORY_STEPS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [31:0]           density,
	input  wire tag_t                  tag_s1,
	input  wire logic signed [31:0]    vel_s1,
	input  wire logic signed [31:0]    tpt_s1,
	input  wire logic                  ker_we,
	input  wire logic [KAW-1:0]        ker_waddr,
	input  wire logic [31:0]           ker_wdata,
	input  wire logic [KAW-1:0]        ker_raddr,
	output logic signed [63:0]         acc,
	output logic                       done
);

	localparam int KDEPTH = DOF_COUNT * HISTORY_STEPS;

	logic [31:0] ker_mem [KDEPTH];
	logic signed [31:0] ker_s1;

	always_ff @(posedge clk) begin
		if (ker_we)
			ker_mem[ker_waddr] <= ker_wdata;
		ker_s1 <= ker_mem[ker_raddr];
	end

	tag_t tag_s2, tag_s3, tag_s4, tag_s5;
	logic [63:0] prod1_s2, prod2_s4;
	logic neg1_s2, neg2_s4;
	logic signed [31:0] vel_s2, vel_s3, coef_s3;
	logic signed [31:0] tpt_s2, tpt_s3, tpt_s4, tpt_s5;
	logic signed [63:0] term_s5;
	logic signed [63:0] sum_q, prev_q, sum_next;
	logic signed [31:0] tprev_q;
	logic signed [63:0] a_s6;
	logic signed [32:0] dt_s6;
	logic vld_s6, last_s6, vld_s7, last_s7, vld_s8, last_s8;
	logic neg_s7;
	logic [64:0] pl_s7, ph_s7;
	logic signed [63:0] area_s8;
	logic [63:0] amag;
	logic [32:0] dmag;
	logic [96:0] prod3;
	logic [79:0] r3;
	logic [79:0] lim3;
	logic [63:0] rs3;
	logic [31:0] kmag, cmag, vmag;

	always_comb begin
		kmag = ker_s1[31] ? 32'(-ker_s1) : 32'(ker_s1);
		cmag = coef_s3[31] ? 32'(-coef_s3) : 32'(coef_s3);
		vmag = vel_s3[31] ? 32'(-vel_s3) : 32'(vel_s3);
		sum_next = (tag_s5.col_first ? 64'sd0 : sum_q) + term_s5;
		amag = a_s6[63] ? 64'(-a_s6) : 64'(a_s6);
		dmag = dt_s6[32] ? 33'(-dt_s6) : 33'(dt_s6);
		prod3 = 97'(pl_s7) + (97'(ph_s7) << 32);
		r3 = 80'((prod3 + 97'd65536) >> 17);
		lim3 = neg_s7 ? {16'd0, 1'b1, 63'd0} : {17'd0, {63{1'b1}}};
		rs3 = (r3 > lim3) ? 64'(lim3) : 64'(r3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2  <= '0;
			tag_s3  <= '0;
			tag_s4  <= '0;
			tag_s5  <= '0;
			vld_s6  <= 1'b0;
			last_s6 <= 1'b0;
			vld_s7  <= 1'b0;
			last_s7 <= 1'b0;
			vld_s8  <= 1'b0;
			last_s8 <= 1'b0;
			done    <= 1'b0;
		end else begin
			tag_s2  <= tag_s1;
			tag_s3  <= tag_s2;
			tag_s4  <= tag_s3;
			tag_s5  <= tag_s4;
			vld_s6  <= tag_s5.vld && tag_s5.col_last && !tag_s5.hist_first;
			last_s6 <= tag_s5.hist_last;
			vld_s7  <= vld_s6;
			last_s7 <= last_s6;
			vld_s8  <= vld_s7;
			last_s8 <= last_s7;
			done    <= vld_s8 && last_s8;
		end
	end

	always_ff @(posedge clk) begin
		prod1_s2 <= 64'(kmag) * 64'(density);
		neg1_s2  <= ker_s1[31];
		vel_s2   <= vel_s1;
		tpt_s2   <= tpt_s1;
		coef_s3  <= sat32(rnd_shift16(prod1_s2, neg1_s2));
		vel_s3   <= vel_s2;
		tpt_s3   <= tpt_s2;
		prod2_s4 <= 64'(cmag) * 64'(vmag);
		neg2_s4  <= coef_s3[31] ^ vel_s3[31];
		tpt_s4   <= tpt_s3;
		term_s5  <= rnd_shift16(prod2_s4, neg2_s4);
		tpt_s5   <= tpt_s4;
		if (tag_s5.vld) begin
			sum_q <= sum_next;
			if (tag_s5.col_last) begin
				a_s6    <= prev_q + sum_next;
				dt_s6   <= 33'(tpt_s5) - 33'(tprev_q);
				prev_q  <= sum_next;
				tprev_q <= tpt_s5;
			end
		end
		pl_s7   <= 65'(amag[31:0]) * 65'(dmag);
		ph_s7   <= 65'(amag[63:32]) * 65'(dmag);
		neg_s7  <= a_s6[63] ^ dt_s6[32];
		area_s8 <= neg_s7 ? -$signed(rs3) : $signed(rs3);
		if (tag_s5.vld && tag_s5.col_last && tag_s5.hist_first)
			acc <= 64'sd0;
		else if (vld_s8)
			acc <= sat_add64(acc, area_s8);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s8) && $past(last_s8))
		else $error("done without final area");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |=> vld_s7)
		else $error("area lost between stages");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |=> vld_s8)
		else $error("product lost between stages");

endmodule
`default_nettype wire

FILE: hdl/radiation_impulse_convolution_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radiation_impulse_convolution_core
// Radiation force by convolution of the velocity history with the kernel.
// ----------------------------------------------------------------------------
// Load items are accepted back to back while the core is idle. A step item
// walks every kernel column of every history step, then drains through the lane
// pipeline and output staging; m_tvalid rises and s_tready returns in the same
// cycle, so the next step transfer can follow; a result still unaccepted at the
// end of the next walk holds that walk back.
// Reset clears control, newest slot and history fill count; kernel and time
// stores hold nothing defined until loaded. No clearing pass is needed.
module radiation_impulse_convolution_core import ricc_pkg::*; #(
	parameter int HISTORY_STEPS = 256,
	parameter int DOF_COUNT     = 6
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [31:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// row_index, col_index, step_index, load_value, vel_x, vel_y, vel_z,
	// ang_vel_x, ang_vel_y, ang_vel_z, zero pad
	input  wire logic [239:0] s_tdata,
	// mode
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// force_x, force_y, force_z, torque_x, torque_y, torque_z
	output logic [191:0]      m_tdata
);

	localparam int KW  = $clog2(HISTORY_STEPS);
	localparam int FW  = $clog2(HISTORY_STEPS + 1);
	localparam int KAW = $clog2(DOF_COUNT * HISTORY_STEPS);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0] state_q;
	logic [31:0] dens_q;
	logic [KW-1:0] newest_q, slot_q, k_q, newest_next;
	logic [CW-1:0] c_q, c_s1;
	logic [FW-1:0] fill_q;
	logic pend_q, in_xfer, step_xfer, issue, out_load;
	logic hvld_s1;
	tag_t tag_s0, tag_s1;

	logic [2:0] row_in, col_in;
	logic [7:0] st_in;
	logic [31:0] load_in;
	logic [31:0] vel_in [DOF_COUNT];

	assign row_in  = s_tdata[2:0];
	assign col_in  = s_tdata[5:3];
	assign st_in   = s_tdata[13:6];
	assign load_in = s_tdata[45:14];

	for (genvar c = 0; c < DOF_COUNT; c++) begin : g_vel
		assign vel_in[c] = s_tdata[46 + 32*c +: 32];
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign step_xfer = in_xfer && (s_tuser == MODE_STEP);
	assign issue     = (state_q == ST_RUN);
	assign out_load  = (state_q == ST_WAIT) && pend_q && (!m_tvalid || m_tready);
	assign newest_next = (newest_q == '0) ? KW'(HISTORY_STEPS - 1) : newest_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dens_q <= DENS_RESET;
		else if (cfg_we)
			dens_q <= cfg_wdata;
	end

	logic lanes_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			newest_q <= '0;
			fill_q   <= '0;
			slot_q   <= '0;
			k_q      <= '0;
			c_q      <= '0;
			pend_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (out_load)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (step_xfer) begin
						newest_q <= newest_next;
						slot_q   <= newest_next;
						k_q      <= '0;
						c_q      <= '0;
						if (fill_q != FW'(HISTORY_STEPS))
							fill_q <= fill_q + 1'b1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (c_q == CW'(DOF_COUNT - 1)) begin
						c_q <= '0;
						k_q <= k_q + 1'b1;
						slot_q <= (slot_q == KW'(HISTORY_STEPS - 1)) ? '0 : slot_q + 1'b1;
						if (k_q == KW'(HISTORY_STEPS - 1))
							state_q <= ST_WAIT;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (out_load) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (lanes_done) begin
						pend_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		tag_s0.vld        = issue;
		tag_s0.col_first  = (c_q == '0);
		tag_s0.col_last   = (c_q == CW'(DOF_COUNT - 1));
		tag_s0.hist_first = (k_q == '0);
		tag_s0.hist_last  = (k_q == KW'(HISTORY_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s1 <= '0;
		else
			tag_s1 <= tag_s0;
	end

	logic [31:0] ring_mem [DOF_COUNT][HISTORY_STEPS];
	logic [31:0] ring_s1 [DOF_COUNT];
	logic [31:0] tpt_mem [HISTORY_STEPS];
	logic signed [31:0] tpt_s1, vel_s1;

	always_ff @(posedge clk) begin
		if (step_xfer)
			for (int c = 0; c < DOF_COUNT; c++)
				ring_mem[c][newest_next] <= vel_in[c];
		for (int c = 0; c < DOF_COUNT; c++)
			ring_s1[c] <= ring_mem[c][slot_q];
		if (in_xfer && s_tuser == MODE_TPT && 32'(st_in) < 32'(HISTORY_STEPS))
			tpt_mem[KW'(st_in)] <= load_in;
		tpt_s1  <= tpt_mem[k_q];
		c_s1    <= c_q;
		hvld_s1 <= (FW'(k_q) < fill_q);
	end

	always_comb begin
		vel_s1 = '0;
		for (int c = 0; c < DOF_COUNT; c++)
			if (c_s1 == CW'(c) && hvld_s1)
				vel_s1 = ring_s1[c];
	end

	logic [KAW-1:0] ker_raddr, ker_waddr;
	logic ker_ok;
	logic signed [63:0] acc [DOF_COUNT];
	logic [DOF_COUNT-1:0] done_v;

	assign ker_raddr = KAW'(c_q) * KAW'(HISTORY_STEPS) + KAW'(k_q);
	assign ker_waddr = KAW'(col_in) * KAW'(HISTORY_STEPS) + KAW'(st_in);
	assign ker_ok = in_xfer && (s_tuser == MODE_KER) && (32'(col_in) < 32'(DOF_COUNT))
		&& (32'(st_in) < 32'(HISTORY_STEPS));
	assign lanes_done = done_v[0];

	for (genvar r = 0; r < DOF_COUNT; r++) begin : g_lane
		ricc_lane #(
			.HISTORY_STEPS(HISTORY_STEPS),
			.DOF_COUNT(DOF_COUNT),
			.KAW(KAW)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.density(dens_q),
			.tag_s1(tag_s1),
			.vel_s1(vel_s1),
			.tpt_s1(tpt_s1),
			.ker_we(ker_ok && (row_in == CW'(r))),
			.ker_waddr(ker_waddr),
			.ker_wdata(load_in),
			.ker_raddr(ker_raddr),
			.acc(acc[r]),
			.done(done_v[r])
		);
	end

	always_ff @(posedge clk) begin
		if (out_load)
			for (int r = 0; r < DOF_MAX; r++)
				m_tdata[32*r +: 32] <= (r < DOF_COUNT) ? neg_sat32(acc[r]) : 32'd0;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		lanes_done |-> state_q == ST_WAIT)
		else $error("lane finished outside wait state");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(pend_q))
		else $error("result shown without pending sum");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !pend_q)
		else $error("stale result pending during walk");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(done_v) == 1'b0 || done_v == '0 || &done_v)
		else $error("lanes out of step");

endmodule
`default_nettype wire
